// ===== rtl/core/cdm_pkg.sv =====
// Shared constants, types and helpers for the comb delay block.
package cdm_pkg;

  localparam int DELAY_DEPTH = 1024;  // entries per channel line, power of two
  localparam int CHANNELS    = 2;     // power of two, at least two

  localparam int PTR_W   = $clog2(DELAY_DEPTH);
  localparam int CH_W    = $clog2(CHANNELS);
  localparam int MEM_DEPTH = DELAY_DEPTH * CHANNELS;
  localparam int ADDR_W  = PTR_W + CH_W;

  localparam int SAMP_W  = 24;
  localparam int COEF_W  = 16;
  localparam int DLY_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam int MA_W    = 29;  // shared multiplier, operand a
  localparam int MB_W    = 18;  // shared multiplier, operand b
  localparam int PROD_W  = MA_W + MB_W;
  localparam int DIFF_W  = 28;
  localparam int MIXS_W  = 44;
  localparam int SPLIT   = 22;
  localparam int TOT_W   = 62;

  localparam logic [COEF_W-1:0] MIX_ONE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FBK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULA,
    ST_WET,
    ST_MULB,
    ST_MIX,
    ST_MULLO,
    ST_MULHI,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clr_addr;
    logic              accept;
    logic              mul_a;
    logic              wet;
    logic              mul_b;
    logic              mix;
    logic              mul_lo;
    logic              mul_hi;
    logic              load_out;
  } cmd_t;

  function automatic logic signed [SAMP_W-1:0] sat24(input logic signed [TOT_W-1:0] v);
    logic signed [TOT_W-1:0] hi_lim;
    logic signed [TOT_W-1:0] lo_lim;
    hi_lim = TOT_W'(signed'(24'sh7FFFFF));
    lo_lim = TOT_W'(signed'(24'sh800000));
    if (v > hi_lim) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < lo_lim) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[SAMP_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/cdm_ram.sv =====
// Generic single-port RAM with registered read.
module cdm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/cdm_ctrl.sv =====
// Sequencer for the comb delay: clearing sweep, per-sample steps, output valid.
module cdm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output cdm_pkg::cmd_t cmd
);
  import cdm_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.clr_addr = clr_addr;
    s_tready     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_WET;
      end
      ST_WET: begin
        cmd.wet    = 1'b1;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_MULLO;
      end
      ST_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MULHI;
      end
      ST_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/core/cdm_dp.sv =====
// Datapath: config registers, delay lines, shared multiplier, output register.
module cdm_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  cdm_pkg::cmd_t                  cmd,
  input  logic                           cfg_valid,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdm_pkg::COEF_W-1:0]     cfg_data,
  input  logic [cdm_pkg::SAMP_W-1:0]     s_tdata,
  input  logic                           s_tuser,
  output logic [cdm_pkg::SAMP_W-1:0]     m_tdata,
  output logic                           m_tuser
);
  import cdm_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_FF = PROD_W'(1 << 11);
  localparam logic signed [PROD_W-1:0] HALF_FB = PROD_W'(1 << 14);
  localparam logic signed [TOT_W-1:0]  HALF_Y  = TOT_W'(1 << 26);

  // configuration
  logic                     mode;
  logic [DLY_W-1:0]         dly;
  logic signed [COEF_W-1:0] gain;
  logic signed [COEF_W-1:0] fbk;
  logic [COEF_W-1:0]        mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      dly  <= DLY_W'(1);
      gain <= 16'sd4096;
      fbk  <= '0;
      mix  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  mode <= cfg_data[0];
        REG_DELAY: dly  <= cfg_data[DLY_W-1:0];
        REG_GAIN:  gain <= signed'(cfg_data);
        REG_FBK:   fbk  <= signed'(cfg_data);
        REG_MIX:   mix  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PTR_W-1:0]  d_eff;
  logic [COEF_W-1:0] m_eff;

  always_comb begin
    if (dly == '0) begin
      d_eff = PTR_W'(1);
    end else if (32'(dly) > 32'(DELAY_DEPTH - 1)) begin
      d_eff = PTR_W'(DELAY_DEPTH - 1);
    end else begin
      d_eff = PTR_W'(dly);
    end
    m_eff = (mix > MIX_ONE) ? MIX_ONE : mix;
  end

  // write pointers and captured request
  logic [PTR_W-1:0]         wp [CHANNELS];
  logic [CH_W-1:0]          line_in;
  logic [CH_W-1:0]          line_r;
  logic                     chan_r;
  logic signed [SAMP_W-1:0] x_r;
  logic [PTR_W-1:0]         rd_ptr;

  assign line_in = CH_W'(s_tuser % CHANNELS);
  assign rd_ptr  = wp[line_in] - d_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) wp[i] <= '0;
    end else if (cmd.wet) begin
      wp[line_r] <= wp[line_r] + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= signed'(s_tdata);
      chan_r <= s_tuser;
      line_r <= line_in;
    end
  end

  // delay memory
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMP_W-1:0]   ram_wdata;
  logic [SAMP_W-1:0]   ram_rdata;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] sum_ff;
  logic signed [PROD_W-1:0] sum_fb;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [DIFF_W-1:0] wet_c;
  logic signed [MIXS_W-1:0] mixsum;

  always_comb begin
    sum_ff    = prod + HALF_FF;
    sum_fb    = prod + HALF_FB;
    diff_next = mode ? DIFF_W'(sum_fb >>> 15) : DIFF_W'(sum_ff >>> 12);
    wet_c     = DIFF_W'(x_r) + diff_next;
  end

  always_comb begin
    ram_we    = cmd.clear | cmd.wet;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_addr = cmd.clr_addr;
    end else if (cmd.wet) begin
      ram_addr  = {line_r, wp[line_r]};
      ram_wdata = mode ? sat24(TOT_W'(wet_c)) : x_r;
    end else begin
      ram_addr = {line_in, rd_ptr};
    end
  end

  cdm_ram #(
    .WIDTH(SAMP_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_a) begin
      mul_a = MA_W'(signed'(ram_rdata));
      mul_b = mode ? MB_W'(fbk) : MB_W'(gain);
    end else if (cmd.mul_b) begin
      mul_a = MA_W'(diff);
      mul_b = signed'({2'b00, m_eff});
    end else if (cmd.mul_lo) begin
      mul_a = signed'({{(MA_W - SPLIT){1'b0}}, mixsum[SPLIT-1:0]});
      mul_b = MB_W'(gain);
    end else begin
      mul_a = MA_W'(signed'(mixsum[MIXS_W-1:SPLIT]));
      mul_b = MB_W'(gain);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.wet) diff <= diff_next;
    if (cmd.mix) mixsum <= MIXS_W'(prod) + (MIXS_W'(x_r) <<< 15);
    if (cmd.mul_hi) acc <= prod;
  end

  // final scale, round, saturate
  logic signed [TOT_W-1:0] total;

  assign total = (TOT_W'(prod) <<< SPLIT) + TOT_W'(acc) + HALF_Y;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= sat24(total >>> 27);
      m_tuser <= chan_r;
    end
  end

endmodule

// ===== rtl/core/comb_delay_with_mix.sv =====
// Top level of the per-channel comb delay with dry/wet mix.
//
// Input stream s_*: one sample per request, tdata = sample_in, tuser = chan.
// Output stream m_*: one result per input, tdata = sample_out, tuser = chan_out.
// Config channel cfg_*: index 0 mode, 1 delay, 2 out gain, 3 feedback gain,
// 4 wet mix; always ready, write only while no sample is in flight.
// Samples are processed one at a time: seven steps follow once the request
// is taken (four of them through the single shared 29x18 multiplier), and
// the next request is taken only back in the idle state.
// A result shows on m_tvalid once the last step loads the output register.
// The output register frees the core: a new request is taken while the last
// result still waits. If the receiver stalls, the next sample runs up to its
// last step and then holds until the output register frees.
// After reset the delay memory (2048 entries) is cleared, one entry a cycle;
// s_tready stays low until the sweep is done. Config writes are taken throughout.
module comb_delay_with_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cdm_pkg::SAMP_W-1:0]    s_tdata,   // [23:0] sample_in
  input  logic                          s_tuser,   // [0] chan
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cdm_pkg::SAMP_W-1:0]    m_tdata,   // [23:0] sample_out
  output logic                          m_tuser,   // [0] chan_out
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdm_pkg::COEF_W-1:0]    cfg_data
);
  import cdm_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  cdm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd)
  );

  cdm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/cdm_checker.sv =====
// Port-level checks for the comb delay, bound to the top level.
module cdm_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [cdm_pkg::SAMP_W-1:0]    s_tdata,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cdm_pkg::SAMP_W-1:0]    m_tdata,
  input logic                          m_tuser,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [cdm_pkg::COEF_W-1:0]    cfg_data
);

  // memory clear runs after reset: right after reset, no request is taken and no result shown
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("request possible or result shown right after reset");

  // one sample in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while a sample is in flight");

  // a new result appears only at the end of a sample's run
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared with no sample in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind comb_delay_with_mix cdm_props u_cdm_checker (.*);

// ===== verif/cdm_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for comb_delay_with_mix: predicts every result and checks it.
module cdm_checker
  import cdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [SAMP_W-1:0]    s_tdata,    // [23:0] sample_in
  input  logic                 s_tuser,    // [0] chan
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [SAMP_W-1:0]    m_tdata,    // [23:0] sample_out
  input  logic                 m_tuser,    // [0] chan_out
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending
);

  typedef struct {
    logic              chan;
    logic [SAMP_W-1:0] smp;
  } comb_result_t;

  logic signed [SAMP_W-1:0] line_mem [CHANNELS][DELAY_DEPTH];
  logic [PTR_W-1:0]         wr_ptr [CHANNELS];

  logic                     fb_mode;
  logic [DLY_W-1:0]         dly_reg;
  logic signed [COEF_W-1:0] gain_reg;
  logic signed [COEF_W-1:0] fbk_reg;
  logic [COEF_W-1:0]        mix_reg;

  comb_result_t             result_q[$];
  int unsigned              errs = 0;

  function automatic longint round_div(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [SAMP_W-1:0] clip24(input longint v);
    if (v > longint'(8388607)) return 24'h7FFFFF;
    if (v < -longint'(8388608)) return 24'h800000;
    return v[SAMP_W-1:0];
  endfunction

  // Advances the channel's delay line by one sample and returns the output.
  function automatic logic [SAMP_W-1:0] comb_step(input logic chan,
                                                  input logic signed [SAMP_W-1:0] x_in);
    longint      x;
    longint      tap;
    longint      wet;
    longint      m;
    longint      acc;
    int unsigned d;
    int unsigned wr;
    int unsigned rd;
    int unsigned line;
    line = chan % CHANNELS;
    x    = x_in;
    d    = dly_reg;
    if (d < 1) d = 1;
    if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
    wr = wr_ptr[line];
    rd = (wr + DELAY_DEPTH - d) % DELAY_DEPTH;
    if (!fb_mode) begin
      line_mem[line][wr] = x_in;
      tap = line_mem[line][rd];
      wet = x + round_div(longint'(gain_reg) * tap, 12);
    end else begin
      tap = line_mem[line][rd];
      wet = x + round_div(longint'(fbk_reg) * tap, 15);
      line_mem[line][wr] = clip24(wet);
    end
    wr_ptr[line] = PTR_W'((wr + 1) % DELAY_DEPTH);
    m   = (mix_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_reg);
    acc = (longint'(32768) - m) * x + m * wet;
    return clip24(round_div(acc * longint'(gain_reg), 27));
  endfunction

  function automatic void flag_mismatch(input string field, input longint want,
                                        input longint got);
    errs++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin : scoreboard
    comb_result_t want;
    if (rst) begin
      foreach (line_mem[c, i]) line_mem[c][i] = '0;
      foreach (wr_ptr[c]) wr_ptr[c] = '0;
      fb_mode  = 1'b0;
      dly_reg  = DLY_W'(1);
      gain_reg = 16'sd4096;
      fbk_reg  = '0;
      mix_reg  = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  fb_mode  = cfg_data[0];
          REG_DELAY: dly_reg  = cfg_data[DLY_W-1:0];
          REG_GAIN:  gain_reg = cfg_data;
          REG_FBK:   fbk_reg  = cfg_data;
          REG_MIX:   mix_reg  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          errs++;
          $error("result with no request pending: chan_out %0d, sample_out %0d",
                 m_tuser, $signed(m_tdata));
        end else begin
          want = result_q.pop_front();
          if (m_tuser !== want.chan) flag_mismatch("chan_out", want.chan, m_tuser);
          if (m_tdata !== want.smp)
            flag_mismatch("sample_out", $signed(want.smp), $signed(m_tdata));
        end
      end
      if (s_tvalid && s_tready) begin
        want.chan = s_tuser;
        want.smp  = comb_step(s_tuser, s_tdata);
        result_q.push_back(want);
      end
    end
    fail_count <= errs;
    pending    <= result_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the comb_delay_with_mix regression: clock, reset, stimulus and verdict.
module testbench;
  import cdm_pkg::*;

  localparam logic MODE_FF = 1'b0;
  localparam logic MODE_FB = 1'b1;

  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int DLY_PAD        = COEF_W - DLY_W;
  localparam int MODE_PAD       = COEF_W - 1;

  localparam logic [SAMP_W-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SAMP_W-1:0] S_MIN = 24'h800000;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [SAMP_W-1:0]    s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SAMP_W-1:0]    m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  int unsigned          fail_count;
  int unsigned          pending;
  logic                 hold_req;
  logic                 no_gaps;

  comb_delay_with_mix u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cdm_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SAMP_W-1:0] pick_sample();
    int   r;
    logic sgn;
    r   = $urandom_range(0, 99);
    sgn = 1'($urandom);
    if (r < 8) return S_MAX;
    if (r < 16) return S_MIN;
    if (r < 30) return SAMP_W'($urandom_range(0, 511) - 256);
    if (r < 45) return {{4{sgn}}, 20'($urandom)};
    return SAMP_W'($urandom);
  endfunction

  task automatic send_sample(input logic chan, input logic [SAMP_W-1:0] smp);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= chan;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused upper bits of mode and delay carry random junk.
  task automatic apply_setting(input logic mode, input logic [DLY_W-1:0] dly,
                               input logic [COEF_W-1:0] gain, input logic [COEF_W-1:0] fbk,
                               input logic [COEF_W-1:0] mix, input bit stray);
    write_reg(REG_MODE, {MODE_PAD'($urandom), mode});
    write_reg(REG_DELAY, {DLY_PAD'($urandom), dly});
    write_reg(REG_GAIN, gain);
    write_reg(REG_FBK, fbk);
    write_reg(REG_MIX, mix);
    if (stray) begin
      for (int i = REG_MIX + 1; i < 2 ** CFG_IDX_W; i++)
        write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setting();
    int                r;
    logic [DLY_W-1:0]  dly;
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] fbk;
    logic [COEF_W-1:0] mix;
    r = $urandom_range(0, 99);
    if (r < 50) dly = DLY_W'($urandom_range(1, 24));
    else if (r < 60) dly = '0;
    else if (r < 70) dly = '1;
    else dly = DLY_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) gain = 16'h7FFF;
    else if (r < 30) gain = 16'h8000;
    else if (r < 50) gain = 16'd4096;
    else if (r < 55) gain = '0;
    else if (r < 80) gain = COEF_W'($urandom_range(0, 8192) - 4096);
    else gain = COEF_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) fbk = 16'h7FFF;
    else if (r < 30) fbk = 16'h8000;
    else if (r < 40) fbk = '0;
    else fbk = COEF_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) mix = '0;
    else if (r < 30) mix = MIX_ONE;
    else if (r < 40) mix = COEF_W'($urandom_range(32769, 65535));
    else mix = COEF_W'($urandom_range(0, 32768));
    apply_setting(1'($urandom), dly, gain, fbk, mix, $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int k;
    bit held;
    held     = 1'b0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // long hold-off: core and output register fill, sample requests stall
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      k = no_gaps ? 0 : pick_gap();
      if (k > 0) begin
        m_tready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("comb_delay_with_mix regression: fail");
    $finish;
  end

  initial begin : stimulus
    int n;
    int sent;
    int phase;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    no_gaps   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: unity gain, dry only
    send_sample(1'b0, S_MAX);
    send_sample(1'b1, S_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, '1);
    send_sample(1'b0, 24'd1);
    send_sample(1'b1, 24'h555555);
    wait_drained();

    // zero delay taken as one, wet mix above one clamped
    apply_setting(MODE_FF, '0, 16'h7FFF, '0, 16'hFFFF, 1'b0);
    send_sample(1'b0, S_MAX);
    send_sample(1'b0, S_MAX);
    send_sample(1'b0, S_MIN);
    send_sample(1'b1, S_MIN);
    send_sample(1'b1, S_MAX);
    wait_drained();

    // longest delay, most negative gains, plus writes to unmapped indexes
    apply_setting(MODE_FB, '1, 16'h8000, 16'h8000, MIX_ONE, 1'b1);
    send_sample(1'b0, S_MIN);
    send_sample(1'b1, S_MAX);
    send_sample(1'b0, 24'hAAAAAA);
    send_sample(1'b1, '1);
    send_sample(1'b0, S_MAX);
    wait_drained();

    // feedback builds up until the stored value saturates
    apply_setting(MODE_FB, DLY_W'(1), 16'h7FFF, 16'h7FFF, 16'd20000, 1'b0);
    repeat (4) send_sample(1'b0, S_MAX);
    repeat (2) send_sample(1'b0, S_MIN);
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = (phase % 6 == 5);
      random_setting();
      n = $urandom_range(20, 70);
      if (phase == 2) begin
        n        = 80;
        hold_req = 1'b1;
      end
      repeat (n) send_sample(1'($urandom), pick_sample());
      sent += n;
      wait_drained();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("comb_delay_with_mix regression: pass");
    else
      $display("comb_delay_with_mix regression: fail");
    $finish;
  end

endmodule
